// ===== rtl/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, codes and fixed-point helpers for the full-pivot LU solver.
// ----------------------------------------------------------------------------
package lfps_pkg;

    localparam int DEF_MAX_ORDER = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [1:0] FUNC_WR_MATRIX = 2'd0;
    localparam logic [1:0] FUNC_WR_VECTOR = 2'd1;
    localparam logic [1:0] FUNC_FACTOR    = 2'd2;
    localparam logic [1:0] FUNC_SOLVE     = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SINGULAR = 2'd1;
    localparam logic [1:0] STAT_NO_LU    = 2'd2;

    localparam logic REG_MATRIX_SIZE     = 1'b0;
    localparam logic REG_PIVOT_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [1:0]          func;
        logic [3:0]          row;
        logic [3:0]          col;
        logic signed [31:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [4:0]          step;
        logic [3:0]          index;
        logic signed [31:0]  solution;
        logic                last;
    } t_out_item;

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat(input logic neg, input logic [64:0] m);
        logic signed [31:0] r;
        if (neg) begin
            if (m >= 65'h0_8000_0000) r = 32'sh8000_0000;
            else r = 32'sd0 - $signed(m[31:0]);
        end else begin
            if (m > 65'h0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
            else r = $signed(m[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = 33'(a) - 33'(b);
        if (d > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (d < -33'sh0_8000_0000) r = 32'sh8000_0000;
        else r = d[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/lfps_div.sv =====
// ----------------------------------------------------------------------------
// lfps_div
// Restoring Q-format divider, one quotient bit per cycle, rounded, saturated.
// ----------------------------------------------------------------------------
module lfps_div #(
    parameter int FRAC_BITS = lfps_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic signed [31:0]  i_den,
    output logic                o_done,
    output logic signed [31:0]  o_quo
);

    localparam int NW   = 33 + FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNTW-1:0]     r_cnt;
    logic [NW-1:0]       r_num;
    logic [32:0]         r_rem;
    logic [31:0]         r_den;
    logic                r_neg;
    logic signed [31:0]  r_quo;

    logic [32:0]         w_rem_sh;
    logic                w_bit;
    logic [32:0]         w_rem_nx;
    logic [NW-1:0]       w_q_nx;
    logic [31:0]         w_mb;

    assign w_mb     = lfps_pkg::mag(i_den);
    assign w_rem_sh = {r_rem[31:0], r_num[NW-1]};
    assign w_bit    = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_bit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
    assign w_q_nx   = {r_num[NW-2:0], w_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[31] ^ i_den[31];
                r_den <= w_mb;
                r_rem <= '0;
                r_num <= (NW'(lfps_pkg::mag(i_num)) << FRAC_BITS) + NW'(w_mb >> 1);
                r_cnt <= CNTW'(NW);
                if (i_den == 32'sd0) begin
                    r_done <= 1'b1;
                    if (i_num == 32'sd0) r_quo <= 32'sd0;
                    else r_quo <= i_num[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_rem_nx;
                r_num <= w_q_nx;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= lfps_pkg::sat(r_neg, 65'(w_q_nx));
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/lu_full_pivot_solver_core.sv =====
// A load is written into its store on the transfer; a solve emits n results.
// One item at a time: the input is not ready while factor or solve runs.
// Reset (synchronous, active low): order 16, threshold 1, identity
// permutations, no valid factorization; stores are undefined until written.
// ----------------------------------------------------------------------------
// lu_full_pivot_solver_core
// Full-pivoting LU factor and solve over a shared multiplier and divider.
// ----------------------------------------------------------------------------
module lu_full_pivot_solver_core #(
    parameter int MAX_ORDER = lfps_pkg::DEF_MAX_ORDER,
    parameter int FRAC_BITS = lfps_pkg::DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lfps_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lfps_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int IW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW  = $clog2(MAX_ORDER + 1);
    localparam int MD  = MAX_ORDER * MAX_ORDER;
    localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_F_NEXT, S_F_SCAN_RD, S_F_SCAN_CMP, S_F_PIV_RD, S_F_PIV,
        S_F_L_RD, S_F_L_DIV, S_F_L_WAIT, S_F_I_NEXT, S_F_U_RD, S_F_A_RD,
        S_F_MUL, S_F_SUB, S_S_FW_INIT, S_S_FW_ACC, S_S_FW_RD, S_S_FW_MUL,
        S_S_FW_SUB, S_S_FW_STORE, S_S_BK_INIT, S_S_BK_ACC, S_S_BK_RD,
        S_S_BK_MUL, S_S_BK_SUB, S_S_BK_DRD, S_S_BK_DIV, S_S_BK_DWAIT,
        S_EMIT_RD, S_EMIT, S_RESULT
    } t_state;

    t_state              r_state;
    logic [4:0]          r_size;
    logic [30:0]         r_thr;
    logic                r_fv;
    logic [CW-1:0]       r_n, r_k, r_i, r_j;
    logic [31:0]         r_best;
    logic [IW-1:0]       r_br, r_bc;
    logic signed [31:0]  r_piv, r_l, r_acc;
    logic [IW-1:0]       r_ro [MAX_ORDER];
    logic [IW-1:0]       r_co [MAX_ORDER];
    logic [1:0]          r_rstat;
    logic [4:0]          r_rstep;
    logic                r_out_valid;
    lfps_pkg::t_out_item r_out;

    logic signed [31:0]  r_mem [MD];
    logic signed [31:0]  r_vec [MAX_ORDER];
    logic signed [31:0]  r_ft  [MAX_ORDER];
    logic signed [31:0]  r_mq, r_vq, r_fq;
    logic [63:0]         r_prod;
    logic                r_pneg;

    logic [MAW-1:0]      w_mra, w_mwa;
    logic                w_mwe, w_vwe, w_fwe;
    logic signed [31:0]  w_mwd, w_vwd;
    logic [IW-1:0]       w_vra, w_vwa, w_fra;
    logic [IW-1:0]       w_ro_i, w_ro_k, w_co_i, w_co_j, w_co_k;
    logic signed [31:0]  w_opa, w_opb, w_prd, w_diff;
    logic [64:0]         w_rnd;
    logic                w_slot, w_div_start, w_div_done;
    logic signed [31:0]  w_div_num, w_div_den, w_div_quo;
    logic [31:0]         w_m, w_best;
    logic [IW-1:0]       w_br, w_bc;
    logic [CW-1:0]       w_nord;
    logic                w_in_acc;

    function automatic logic [MAW-1:0] cell_addr(input logic [IW-1:0] r,
                                                 input logic [IW-1:0] c);
        return MAW'(MAW'(r) * MAW'(MAX_ORDER)) + MAW'(c);
    endfunction

    assign w_ro_i = r_ro[r_i[IW-1:0]];
    assign w_ro_k = r_ro[r_k[IW-1:0]];
    assign w_co_i = r_co[r_i[IW-1:0]];
    assign w_co_j = r_co[r_j[IW-1:0]];
    assign w_co_k = r_co[r_k[IW-1:0]];

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_slot   = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_size == 5'd0) w_nord = CW'(1);
        else if (int'(r_size) > MAX_ORDER) w_nord = CW'(MAX_ORDER);
        else w_nord = CW'(r_size);
    end

    always_comb begin
        case (r_state)
            S_F_SCAN_RD, S_F_U_RD,
            S_S_FW_RD, S_S_BK_RD: w_mra = cell_addr(w_ro_i, w_co_j);
            S_F_PIV_RD:           w_mra = cell_addr(w_ro_k, w_co_k);
            S_F_L_RD:             w_mra = cell_addr(w_ro_i, w_co_k);
            S_F_A_RD:             w_mra = cell_addr(w_ro_k, w_co_j);
            S_S_BK_DRD:           w_mra = cell_addr(w_ro_i, w_co_i);
            default:              w_mra = '0;
        endcase
        case (r_state)
            S_S_FW_INIT: w_vra = w_ro_i;
            S_S_BK_RD:   w_vra = w_co_j;
            default:     w_vra = r_i[IW-1:0];
        endcase
        w_fra = (r_state == S_S_FW_RD) ? r_j[IW-1:0] : r_i[IW-1:0];
    end

    always_comb begin
        case (r_state)
            S_F_MUL:    begin w_opa = r_l;  w_opb = r_mq; end
            S_S_FW_MUL: begin w_opa = r_mq; w_opb = r_fq; end
            default:    begin w_opa = r_mq; w_opb = r_vq; end
        endcase
        w_rnd  = (65'(r_prod) + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        w_prd  = lfps_pkg::sat(r_pneg, w_rnd);
        w_diff = lfps_pkg::sub_sat(r_acc, w_prd);
    end

    always_comb begin
        w_m    = lfps_pkg::mag(r_mq);
        w_best = r_best;
        w_br   = r_br;
        w_bc   = r_bc;
        if (w_m > r_best) begin
            w_best = w_m;
            w_br   = r_i[IW-1:0];
            w_bc   = r_j[IW-1:0];
        end
    end

    always_comb begin
        w_mwe = 1'b0;
        w_mwa = cell_addr(w_ro_i, w_co_j);
        w_mwd = w_diff;
        w_vwe = 1'b0;
        w_vwa = w_co_i;
        w_vwd = w_div_quo;
        w_fwe = (r_state == S_S_FW_STORE);
        case (r_state)
            S_IDLE: begin
                w_mwa = cell_addr(IW'(i_in_data.row), IW'(i_in_data.col));
                w_mwd = i_in_data.value;
                w_vwa = IW'(i_in_data.row);
                w_vwd = i_in_data.value;
                w_mwe = w_in_acc && (i_in_data.func == lfps_pkg::FUNC_WR_MATRIX)
                        && (int'(i_in_data.row) < MAX_ORDER)
                        && (int'(i_in_data.col) < MAX_ORDER);
                w_vwe = w_in_acc && (i_in_data.func == lfps_pkg::FUNC_WR_VECTOR)
                        && (int'(i_in_data.row) < MAX_ORDER);
            end
            S_F_L_WAIT: begin
                w_mwa = cell_addr(w_ro_i, w_co_k);
                w_mwd = w_div_quo;
                w_mwe = w_div_done;
            end
            S_F_SUB:      w_mwe = 1'b1;
            S_S_BK_DWAIT: w_vwe = w_div_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[w_mwa] <= w_mwd;
        r_mq <= r_mem[w_mra];
    end

    always_ff @(posedge i_clk) begin
        if (w_vwe) r_vec[w_vwa] <= w_vwd;
        r_vq <= r_vec[w_vra];
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) r_ft[r_i[IW-1:0]] <= r_acc;
        r_fq <= r_ft[w_fra];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(lfps_pkg::mag(w_opa)) * 64'(lfps_pkg::mag(w_opb));
        r_pneg <= w_opa[31] ^ w_opb[31];
    end

    assign w_div_start = (r_state == S_F_L_DIV) || (r_state == S_S_BK_DIV);
    assign w_div_num   = (r_state == S_F_L_DIV) ? r_mq : r_acc;
    assign w_div_den   = (r_state == S_F_L_DIV) ? r_piv : r_mq;

    lfps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= 5'd16;
            r_thr       <= 31'd1;
            r_fv        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int q = 0; q < MAX_ORDER; q++) begin
                r_ro[q] <= IW'(q);
                r_co[q] <= IW'(q);
            end
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lfps_pkg::REG_MATRIX_SIZE: begin
                        r_size <= i_cfg_data[4:0];
                        r_fv   <= 1'b0;
                    end
                    lfps_pkg::REG_PIVOT_THRESHOLD: r_thr <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_n <= w_nord;
                    if (w_in_acc) begin
                        case (i_in_data.func)
                            lfps_pkg::FUNC_WR_MATRIX:
                                if (w_mwe) r_fv <= 1'b0;
                            lfps_pkg::FUNC_FACTOR: begin
                                for (int q = 0; q < MAX_ORDER; q++) begin
                                    r_ro[q] <= IW'(q);
                                    r_co[q] <= IW'(q);
                                end
                                r_k     <= '0;
                                r_i     <= '0;
                                r_j     <= '0;
                                r_best  <= '0;
                                r_br    <= '0;
                                r_bc    <= '0;
                                r_state <= S_F_SCAN_RD;
                            end
                            lfps_pkg::FUNC_SOLVE: begin
                                r_i <= '0;
                                if (r_fv) begin
                                    r_state <= S_S_FW_INIT;
                                end else begin
                                    r_rstat <= lfps_pkg::STAT_NO_LU;
                                    r_rstep <= '0;
                                    r_state <= S_RESULT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_F_NEXT: begin
                    if (r_k + 1'b1 == r_n) begin
                        r_fv    <= 1'b1;
                        r_rstat <= lfps_pkg::STAT_OK;
                        r_rstep <= '0;
                        r_state <= S_RESULT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_i     <= r_k + 1'b1;
                        r_j     <= r_k + 1'b1;
                        r_best  <= '0;
                        r_br    <= IW'(r_k + 1'b1);
                        r_bc    <= IW'(r_k + 1'b1);
                        r_state <= S_F_SCAN_RD;
                    end
                end
                S_F_SCAN_RD: r_state <= S_F_SCAN_CMP;
                S_F_SCAN_CMP: begin
                    r_best <= w_best;
                    r_br   <= w_br;
                    r_bc   <= w_bc;
                    if (r_j + 1'b1 != r_n) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_F_SCAN_RD;
                    end else if (r_i + 1'b1 != r_n) begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= r_k;
                        r_state <= S_F_SCAN_RD;
                    end else if (w_best < {1'b0, r_thr}) begin
                        r_fv    <= 1'b0;
                        r_rstat <= lfps_pkg::STAT_SINGULAR;
                        r_rstep <= 5'(r_k) + 5'd1;
                        r_state <= S_RESULT;
                    end else begin
                        r_ro[r_k[IW-1:0]] <= r_ro[w_br];
                        r_ro[w_br]        <= w_ro_k;
                        r_co[r_k[IW-1:0]] <= r_co[w_bc];
                        r_co[w_bc]        <= w_co_k;
                        r_state           <= S_F_PIV_RD;
                    end
                end
                S_F_PIV_RD: r_state <= S_F_PIV;
                S_F_PIV: begin
                    r_piv <= r_mq;
                    r_i   <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 == r_n) ? S_F_NEXT : S_F_L_RD;
                end
                S_F_L_RD: r_state <= S_F_L_DIV;
                S_F_L_DIV: r_state <= S_F_L_WAIT;
                S_F_L_WAIT: begin
                    if (w_div_done) begin
                        r_l     <= w_div_quo;
                        r_j     <= r_k + 1'b1;
                        r_state <= S_F_U_RD;
                    end
                end
                S_F_I_NEXT: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_n) ? S_F_NEXT : S_F_L_RD;
                end
                S_F_U_RD: r_state <= S_F_A_RD;
                S_F_A_RD: begin
                    r_acc   <= r_mq;
                    r_state <= S_F_MUL;
                end
                S_F_MUL: r_state <= S_F_SUB;
                S_F_SUB: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 == r_n) ? S_F_I_NEXT : S_F_U_RD;
                end
                S_S_FW_INIT: r_state <= S_S_FW_ACC;
                S_S_FW_ACC: begin
                    r_acc   <= r_vq;
                    r_j     <= '0;
                    r_state <= (r_i == '0) ? S_S_FW_STORE : S_S_FW_RD;
                end
                S_S_FW_RD:  r_state <= S_S_FW_MUL;
                S_S_FW_MUL: r_state <= S_S_FW_SUB;
                S_S_FW_SUB: begin
                    r_acc   <= w_diff;
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 == r_i) ? S_S_FW_STORE : S_S_FW_RD;
                end
                S_S_FW_STORE: begin
                    if (r_i + 1'b1 == r_n) begin
                        r_state <= S_S_BK_INIT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_S_FW_INIT;
                    end
                end
                S_S_BK_INIT: r_state <= S_S_BK_ACC;
                S_S_BK_ACC: begin
                    r_acc   <= r_fq;
                    r_j     <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_n) ? S_S_BK_DRD : S_S_BK_RD;
                end
                S_S_BK_RD:  r_state <= S_S_BK_MUL;
                S_S_BK_MUL: r_state <= S_S_BK_SUB;
                S_S_BK_SUB: begin
                    r_acc   <= w_diff;
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 == r_n) ? S_S_BK_DRD : S_S_BK_RD;
                end
                S_S_BK_DRD: r_state <= S_S_BK_DIV;
                S_S_BK_DIV: r_state <= S_S_BK_DWAIT;
                S_S_BK_DWAIT: begin
                    if (w_div_done) begin
                        if (r_i == '0) begin
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_state <= S_S_BK_INIT;
                        end
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_valid       <= 1'b1;
                        r_out.status      <= lfps_pkg::STAT_OK;
                        r_out.step        <= '0;
                        r_out.index       <= 4'(r_i);
                        r_out.solution    <= r_vq;
                        r_out.last        <= (r_i + 1'b1 == r_n);
                        r_i               <= r_i + 1'b1;
                        r_state           <= (r_i + 1'b1 == r_n) ? S_IDLE : S_EMIT_RD;
                    end
                end
                S_RESULT: begin
                    if (w_slot) begin
                        r_out_valid    <= 1'b1;
                        r_out.status   <= r_rstat;
                        r_out.step     <= r_rstep;
                        r_out.index    <= '0;
                        r_out.solution <= '0;
                        r_out.last     <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != lfps_pkg::STAT_OK |-> o_out_data.last)
        else $error("error result not marked last");
    a_bk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_S_BK_RD |-> r_j < r_n && r_j > r_i)
        else $error("back substitution index out of range");
    a_fv_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fv) |-> $past(r_state) == S_F_NEXT)
        else $error("factorization marked valid outside factor");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_F_L_WAIT || r_state == S_S_BK_DWAIT)
        else $error("divider result with no consumer");
`endif

endmodule

// ===== test/tb_lu_full_pivot_solver_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lu_full_pivot_solver_core
// Loads small square systems, factors and solves them through the core, and
// compares every result against an in-bench fixed-point LU predictor, with
// random idle gaps on both channels and register changes between phases.
// ----------------------------------------------------------------------------
module tb_lu_full_pivot_solver_core;

    localparam int ORD_MAX  = lfps_pkg::DEF_MAX_ORDER;
    localparam int FB       = lfps_pkg::DEF_FRAC_BITS;
    localparam int LIMIT    = 600000;
    localparam int SETTLE   = 64;
    localparam int N_ITEMS  = 120;
    localparam int RX_HOLD  = 2000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    lfps_pkg::t_in_item  in_data = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_index = 1'b0;
    logic [31:0]         cfg_data = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_cfg_ready;
    lfps_pkg::t_out_item o_out_data;

    lu_full_pivot_solver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] lu_a   [0:ORD_MAX*ORD_MAX-1];
    logic signed [31:0] rhs_x  [0:ORD_MAX-1];
    logic signed [31:0] fwd_y  [0:ORD_MAX-1];
    int unsigned        rperm  [0:ORD_MAX-1];
    int unsigned        cperm  [0:ORD_MAX-1];
    bit                 lu_ok = 1'b0;
    logic [4:0]         size_reg = 5'd16;
    longint unsigned    thr_reg = 1;

    lfps_pkg::t_in_item  cmd_q [$];
    lfps_pkg::t_out_item want_q [$];
    int        errors = 0;
    int        items = 0;
    int        cycles = 0;
    int        tx_gap = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;
    int        rx_stall = 0;
    int        rx_draw;
    bit        rx_long_req = 1'b0;
    bit        rx_long_ack = 1'b0;

    function automatic longint unsigned magn(logic signed [31:0] v);
        return v < 0 ? longint'(0) - longint'(v) : longint'(v);
    endfunction

    function automatic logic signed [31:0] clamp(bit neg, longint unsigned m);
        if (neg) begin
            return (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(longint'(0) - longint'(m));
        end
        return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint unsigned m;
        m = magn(a) * magn(b);
        m = (m + (64'd1 << (FB - 1))) >> FB;
        return clamp((a < 0) != (b < 0), m);
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] b);
        longint unsigned mb, m;
        if (b == 0) begin
            if (a == 0) return 32'sd0;
            return a < 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        mb = magn(b);
        m = ((magn(a) << FB) + mb / 2) / mb;
        return clamp((a < 0) != (b < 0), m);
    endfunction

    function automatic logic signed [31:0] q_sub(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (d < -64'sh8000_0000) return 32'sh8000_0000;
        return 32'(d);
    endfunction

    function automatic int unsigned order_n();
        if (size_reg == 0) return 1;
        if (size_reg > ORD_MAX) return ORD_MAX;
        return size_reg;
    endfunction

    function automatic int unsigned at(int unsigned r, int unsigned c);
        return (r % ORD_MAX) * ORD_MAX + (c % ORD_MAX);
    endfunction

    function automatic void expect_result(logic [1:0] st, logic [4:0] stp, logic [3:0] ix,
                                          logic signed [31:0] sol, logic lst);
        lfps_pkg::t_out_item o;
        o.status = st;
        o.step = stp;
        o.index = ix;
        o.solution = sol;
        o.last = lst;
        want_q.push_back(o);
    endfunction

    function automatic void lu_factor();
        int unsigned n, br, bc, h;
        longint unsigned best, m;
        logic signed [31:0] l;
        n = order_n();
        for (int i = 0; i < ORD_MAX; i++) begin
            rperm[i] = i;
            cperm[i] = i;
        end
        for (int k = 0; k < n; k++) begin
            best = 0;
            br = k;
            bc = k;
            for (int i = k; i < n; i++) begin
                for (int j = k; j < n; j++) begin
                    m = magn(lu_a[at(rperm[i], cperm[j])]);
                    if (m > best) begin
                        best = m;
                        br = i;
                        bc = j;
                    end
                end
            end
            if (best < thr_reg) begin
                lu_ok = 1'b0;
                expect_result(lfps_pkg::STAT_SINGULAR, 5'(k + 1), 4'd0, 32'sd0, 1'b1);
                return;
            end
            h = rperm[k]; rperm[k] = rperm[br]; rperm[br] = h;
            h = cperm[k]; cperm[k] = cperm[bc]; cperm[bc] = h;
            for (int i = k + 1; i < n; i++) begin
                l = q_div(lu_a[at(rperm[i], cperm[k])], lu_a[at(rperm[k], cperm[k])]);
                lu_a[at(rperm[i], cperm[k])] = l;
                for (int j = k + 1; j < n; j++) begin
                    lu_a[at(rperm[i], cperm[j])] = q_sub(lu_a[at(rperm[i], cperm[j])],
                        q_mul(l, lu_a[at(rperm[k], cperm[j])]));
                end
            end
        end
        lu_ok = 1'b1;
        expect_result(lfps_pkg::STAT_OK, 5'd0, 4'd0, 32'sd0, 1'b1);
    endfunction

    function automatic void lu_solve();
        int unsigned n;
        logic signed [31:0] acc;
        n = order_n();
        if (!lu_ok) begin
            expect_result(lfps_pkg::STAT_NO_LU, 5'd0, 4'd0, 32'sd0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            acc = rhs_x[rperm[i] % ORD_MAX];
            for (int j = 0; j < i; j++)
                acc = q_sub(acc, q_mul(lu_a[at(rperm[i], cperm[j])], fwd_y[j]));
            fwd_y[i] = acc;
        end
        for (int i = n - 1; i >= 0; i--) begin
            acc = fwd_y[i];
            for (int j = i + 1; j < n; j++)
                acc = q_sub(acc, q_mul(lu_a[at(rperm[i], cperm[j])],
                                       rhs_x[cperm[j] % ORD_MAX]));
            rhs_x[cperm[i] % ORD_MAX] = q_div(acc, lu_a[at(rperm[i], cperm[i])]);
        end
        for (int i = 0; i < n; i++)
            expect_result(lfps_pkg::STAT_OK, 5'd0, 4'(i), rhs_x[i], i + 1 == n);
    endfunction

    function automatic void apply_item(lfps_pkg::t_in_item it);
        case (it.func)
            lfps_pkg::FUNC_WR_MATRIX: begin
                lu_a[at(it.row, it.col)] = it.value;
                lu_ok = 1'b0;
            end
            lfps_pkg::FUNC_WR_VECTOR: rhs_x[it.row] = it.value;
            lfps_pkg::FUNC_FACTOR:    lu_factor();
            default:                  lu_solve();
        endcase
    endfunction

    function automatic int draw_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(string what, longint got, longint exp_v);
        $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, exp_v, cycles);
        errors++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (tx_gap > 0 || cmd_q.size() == 0) begin
                in_valid <= 1'b0;
                if (tx_gap > 0) tx_gap <= tx_gap - 1;
            end else begin
                in_valid <= 1'b1;
                in_data <= cmd_q.pop_front();
                tx_gap <= draw_gap(tx_steady);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) apply_item(in_data);
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (rx_long_req != rx_long_ack && o_out_valid) begin
            rx_long_ack <= rx_long_req;
            out_ready <= 1'b0;
            rx_stall <= RX_HOLD;
        end else begin
            rx_draw = draw_gap(rx_steady);
            out_ready <= (rx_draw == 0);
            rx_stall <= (rx_draw > 0) ? rx_draw - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        lfps_pkg::t_out_item w;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (want_q.size() == 0) begin
                report("unexpected result", o_out_data, 0);
            end else begin
                w = want_q.pop_front();
                if (o_out_data.status !== w.status) report("status", o_out_data.status, w.status);
                if (o_out_data.step !== w.step) report("step", o_out_data.step, w.step);
                if (o_out_data.index !== w.index) report("index", o_out_data.index, w.index);
                if (o_out_data.solution !== w.solution)
                    report("solution", o_out_data.solution, w.solution);
                if (o_out_data.last !== w.last) report("last", o_out_data.last, w.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] f, int r, int c, logic signed [31:0] v);
        lfps_pkg::t_in_item it;
        it.func = f;
        it.row = 4'(r);
        it.col = 4'(c);
        it.value = v;
        cmd_q.push_back(it);
        items++;
    endtask

    task automatic write_reg(logic idx, logic [31:0] d);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == lfps_pkg::REG_MATRIX_SIZE) begin
            size_reg = d[4:0];
            lu_ok = 1'b0;
        end else begin
            thr_reg = d[30:0];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (cmd_q.size() != 0 || in_valid || want_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_val(int kind, bit diag);
        logic signed [31:0] v;
        case (kind)
            0: begin
                v = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
                if (diag) v = v + ($urandom_range(0, 1) ? (12 << 16) : -(12 << 16));
            end
            1: v = $urandom;
            default: begin
                case ($urandom_range(0, 6))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sd0;
                    3: v = 32'sd1;
                    4: v = -32'sd1;
                    5: v = 32'sh0001_0000;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // write the whole n-by-n block and the first n vector entries in random order
    task automatic load_system(int n, int kind);
        lfps_pkg::t_in_item wr [$];
        lfps_pkg::t_in_item h;
        int k;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                h.func = lfps_pkg::FUNC_WR_MATRIX;
                h.row = 4'(r);
                h.col = 4'(c);
                h.value = pick_val(kind, r == c);
                wr.push_back(h);
            end
            h.func = lfps_pkg::FUNC_WR_VECTOR;
            h.row = 4'(r);
            h.col = 4'($urandom_range(0, 15));
            h.value = pick_val(kind, 1'b0);
            wr.push_back(h);
        end
        for (int i = wr.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            h = wr[i];
            wr[i] = wr[k];
            wr[k] = h;
        end
        foreach (wr[i]) push_item(wr[i].func, wr[i].row, wr[i].col, wr[i].value);
    endtask

    initial begin
        int n, r, kind;
        for (int i = 0; i < ORD_MAX; i++) begin
            rperm[i] = i;
            cperm[i] = i;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // solve right after reset: no factorization
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        wait_idle();

        // order 0 acts as 1, zero pivot accepted with threshold 0
        write_reg(lfps_pkg::REG_MATRIX_SIZE, 32'd0);
        write_reg(lfps_pkg::REG_PIVOT_THRESHOLD, 32'd0);
        push_item(lfps_pkg::FUNC_WR_MATRIX, 0, 0, 0);
        push_item(lfps_pkg::FUNC_WR_VECTOR, 0, 15, 32'sh7FFF_FFFF);
        push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        push_item(lfps_pkg::FUNC_WR_VECTOR, 0, 0, 32'sh8000_0000);
        push_item(lfps_pkg::FUNC_SOLVE, 15, 15, -32'sd1);
        wait_idle();

        // all-zero 2x2: singular at step 1, then zero pivots with threshold 0
        write_reg(lfps_pkg::REG_MATRIX_SIZE, 32'd2);
        write_reg(lfps_pkg::REG_PIVOT_THRESHOLD, 32'd1);
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) push_item(lfps_pkg::FUNC_WR_MATRIX, i, j, 0);
            push_item(lfps_pkg::FUNC_WR_VECTOR, i, 0, 32'sh0003_0000);
        end
        push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        wait_idle();
        write_reg(lfps_pkg::REG_PIVOT_THRESHOLD, 32'd0);
        push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        wait_idle();

        // top threshold: only the extreme values pass, then singular
        write_reg(lfps_pkg::REG_MATRIX_SIZE, 32'd3);
        write_reg(lfps_pkg::REG_PIVOT_THRESHOLD, 32'hFFFF_FFFF);
        load_system(3, 0);
        push_item(lfps_pkg::FUNC_WR_MATRIX, 2, 1, 32'sh8000_0000);
        push_item(lfps_pkg::FUNC_WR_MATRIX, 15, 15, 32'sh7FFF_FFFF);
        push_item(lfps_pkg::FUNC_WR_VECTOR, 15, 0, -32'sd1);
        push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        wait_idle();

        // matrix write after a good factor invalidates it
        write_reg(lfps_pkg::REG_PIVOT_THRESHOLD, 32'd1);
        push_item(lfps_pkg::FUNC_WR_MATRIX, 2, 1, 32'sh0002_0000);
        push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
        push_item(lfps_pkg::FUNC_WR_MATRIX, 0, 2, 32'sh0000_8000);
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        wait_idle();

        for (int ph = 0; items < N_ITEMS - 16; ph++) begin
            r = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 4) : $urandom_range(5, 6);
            r = $urandom_range(0, 99);
            kind = (r < 70) ? 0 : (r < 85) ? 1 : 2;
            write_reg(lfps_pkg::REG_MATRIX_SIZE,
                      (n == 1 && $urandom_range(0, 1)) ? 32'd0 : 32'(n));
            r = $urandom_range(0, 99);
            write_reg(lfps_pkg::REG_PIVOT_THRESHOLD, (r < 60) ? 32'd1 : (r < 80) ?
                      $urandom_range(0, 1 << 16) : (r < 88) ? 32'd0 : $urandom);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if (ph == 1) begin
                @(posedge i_clk);
                rx_long_req <= ~rx_long_req;
            end
            load_system(n, kind);
            push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
            if ($urandom_range(0, 9) == 0) push_item(lfps_pkg::FUNC_FACTOR, 0, 0, 0);
            push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
            if (ph == 1) push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 1))
                        push_item(lfps_pkg::FUNC_WR_VECTOR, i, 0, pick_val(kind, 0));
                push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
            end else if (r < 45) begin
                push_item(lfps_pkg::FUNC_WR_MATRIX, $urandom_range(0, n - 1),
                          $urandom_range(0, n - 1), pick_val(kind, 0));
                push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
            end
            wait_idle();
        end

        // size register above the maximum clears the factorization
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        write_reg(lfps_pkg::REG_MATRIX_SIZE, 32'd31);
        push_item(lfps_pkg::FUNC_SOLVE, 0, 0, 0);
        wait_idle();

        if (want_q.size() != 0) report("results never arrived", want_q.size(), 0);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lfps_pkg.sv
rtl/lfps_div.sv
rtl/lu_full_pivot_solver_core.sv
test/tb_lu_full_pivot_solver_core.sv
